// File: rtl/core/psf_pkg.sv
package psf_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 40;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_FORWARD_ONLY = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NORMAL_X     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NORMAL_Z     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_THICK   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_RANGE_SQ = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_RANGE_SQ = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RING_LENGTH  = 3'd6;

  localparam logic CMD_FILTER     = 1'b0;
  localparam logic CMD_MASK_WRITE = 1'b1;

  localparam int MASK_INDEX_BITS = 18;
  localparam int RING_LEN_BITS   = 19;
  localparam int RANGE_BITS      = 40;
  localparam int NORMAL_BITS     = 16;
  localparam int THICK_BITS      = 16;

  typedef struct packed {
    logic                           forward_only;
    logic signed [NORMAL_BITS-1:0]  normal_x;
    logic signed [NORMAL_BITS-1:0]  normal_z;
    logic [THICK_BITS-1:0]          half_thickness_mm;
    logic [RANGE_BITS-1:0]          min_range_sq;
    logic [RANGE_BITS-1:0]          max_range_sq;
    logic [RING_LEN_BITS-1:0]       ring_length;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    forward_only:      1'b1,
    normal_x:          -16'sd6252,
    normal_z:          16'sd32166,
    half_thickness_mm: 16'd50,
    min_range_sq:      40'd90000,
    max_range_sq:      40'd225000000,
    ring_length:       19'd200000
  };

endpackage

// File: rtl/core/plane_slab_point_filter_core.sv
// Slab and range filter for a stream of lidar points in signed millimetres.
// Items enter on the s_ channel. s_tuser carries the command: filter a point,
// or write one keep mask entry. A mask write produces no result and puts the
// ring position back to zero. A filter item reads the mask bit at the ring
// position, advances the ring, and, if it passes every test, leaves as one
// item on the m_ channel holding x and y.
// One item is accepted per cycle while s_tready is high. A passing point
// raises m_tvalid through five register stages, the first of which loads at
// the accepting edge: the mask read, the products, the first sums, the slab
// compare with the last sum, and the range compare.
// The user must write the registers over the cfg_ port only while the block
// is idle; the block itself does not enforce this.
// When the receiver stalls, results collect in the pipeline stages and
// s_tready falls only once every stage holds a waiting point; dropped points
// leave gaps that later points close up.
// Synchronous reset restores the register defaults, empties the pipeline and
// sets the ring position to zero. The keep mask is not cleared: entries must
// be written before the ring reaches them.
module plane_slab_point_filter_core #(
  parameter int MASK_DEPTH = 262144,
  parameter int COORD_BITS = 20
) (
  input  logic clk,
  input  logic rst,

  input  logic                                        cfg_wr_en,
  input  logic [psf_pkg::CFG_INDEX_BITS-1:0]          cfg_addr,
  input  logic [psf_pkg::CFG_DATA_BITS-1:0]           cfg_wdata,

  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // x_mm, y_mm, z_mm, mask_index, mask_bit, zero fill
  input  logic [((3*COORD_BITS+psf_pkg::MASK_INDEX_BITS+1+7)/8)*8-1:0] s_tdata,
  // command
  input  logic                                        s_tuser,

  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // out_x_mm, out_y_mm, zero fill
  output logic [((2*COORD_BITS+7)/8)*8-1:0]           m_tdata
);

  localparam int CW    = COORD_BITS;
  localparam int IB    = psf_pkg::MASK_INDEX_BITS;
  localparam int OUT_W = ((2*CW+7)/8)*8;
  localparam int AW    = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
  localparam int LW    = (AW + 1 > psf_pkg::RING_LEN_BITS) ? AW + 1 : psf_pkg::RING_LEN_BITS;
  localparam int PW    = CW + psf_pkg::NORMAL_BITS;
  localparam int SLW   = (CW + psf_pkg::NORMAL_BITS + 1 > 33) ?
                         CW + psf_pkg::NORMAL_BITS + 1 : 33;
  localparam int SQW   = 2*CW + 1;
  localparam int CMPW  = (SQW > psf_pkg::RANGE_BITS) ? SQW : psf_pkg::RANGE_BITS;
  localparam logic [LW-1:0] DEPTH_L = LW'(MASK_DEPTH);

  psf_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= psf_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        psf_pkg::CFG_FORWARD_ONLY: cfg.forward_only      <= cfg_wdata[0];
        psf_pkg::CFG_NORMAL_X:     cfg.normal_x          <= $signed(cfg_wdata[15:0]);
        psf_pkg::CFG_NORMAL_Z:     cfg.normal_z          <= $signed(cfg_wdata[15:0]);
        psf_pkg::CFG_HALF_THICK:   cfg.half_thickness_mm <= cfg_wdata[15:0];
        psf_pkg::CFG_MIN_RANGE_SQ: cfg.min_range_sq      <= cfg_wdata[39:0];
        psf_pkg::CFG_MAX_RANGE_SQ: cfg.max_range_sq      <= cfg_wdata[39:0];
        psf_pkg::CFG_RING_LENGTH:  cfg.ring_length       <= cfg_wdata[18:0];
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] in_x, in_y, in_z;
  logic [IB-1:0]        in_index;
  logic                 in_bit;
  logic                 accept, accept_filter, accept_write;

  assign in_x     = $signed(s_tdata[CW-1:0]);
  assign in_y     = $signed(s_tdata[2*CW-1:CW]);
  assign in_z     = $signed(s_tdata[3*CW-1:2*CW]);
  assign in_index = s_tdata[3*CW+IB-1:3*CW];
  assign in_bit   = s_tdata[3*CW+IB];

  assign accept        = s_tvalid && s_tready;
  assign accept_filter = accept && (s_tuser == psf_pkg::CMD_FILTER);
  assign accept_write  = accept && (s_tuser == psf_pkg::CMD_MASK_WRITE);

  logic [AW-1:0] ring_pos;
  logic [LW-1:0] len_eff, pos_inc, index_ext;
  logic          index_ok;

  assign len_eff   = (LW'(cfg.ring_length) > DEPTH_L) ? DEPTH_L : LW'(cfg.ring_length);
  assign pos_inc   = LW'(ring_pos) + LW'(1);
  assign index_ext = LW'(in_index);
  assign index_ok  = index_ext < DEPTH_L;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pos <= '0;
    end else if (accept_write) begin
      ring_pos <= '0;
    end else if (accept_filter) begin
      ring_pos <= (pos_inc >= len_eff) ? '0 : pos_inc[AW-1:0];
    end
  end

  logic mask_q;

  psf_ram #(
    .WIDTH (1),
    .DEPTH (MASK_DEPTH)
  ) u_mask (
    .clk     (clk),
    .wr_en   (accept_write && index_ok),
    .wr_addr (index_ext[AW-1:0]),
    .wr_data (in_bit),
    .rd_en   (accept_filter),
    .rd_addr (ring_pos),
    .rd_data (mask_q)
  );

  logic                 s1_v, s2_v, s3_v, s4_v, out_v;
  logic                 s1_en, s2_en, s3_en, s4_en, out_en;
  logic signed [CW-1:0] s1_x, s1_y, s1_z;
  logic signed [CW-1:0] s2_x, s2_y, s3_x, s3_y, s4_x, s4_y;
  logic signed [PW-1:0] s2_px, s2_pz;
  logic [2*CW-1:0]      s2_xx, s2_yy, s2_zz, s3_zz;
  logic signed [2*CW-1:0] sq_x, sq_y, sq_z;
  logic signed [SLW-1:0] s3_slab, slab_lim;
  logic [SQW-1:0]       s3_r2a, s4_r2;
  logic                 slab_ok, range_ok, front_drop;
  logic signed [CW-1:0] out_x, out_y;

  assign out_en = !out_v || m_tready;
  assign s4_en  = !s4_v || out_en;
  assign s3_en  = !s3_v || s4_en;
  assign s2_en  = !s2_v || s3_en;
  assign s1_en  = !s1_v || s2_en;
  assign s_tready = s1_en;

  assign front_drop = cfg.forward_only && s1_x[CW-1];
  assign sq_x = s1_x * s1_x;
  assign sq_y = s1_y * s1_y;
  assign sq_z = s1_z * s1_z;

  assign slab_lim = $signed(SLW'({cfg.half_thickness_mm, 15'd0}));
  assign slab_ok  = (s3_slab < slab_lim) && (s3_slab > -slab_lim);
  assign range_ok = (CMPW'(s4_r2) >= CMPW'(cfg.min_range_sq)) &&
                    (CMPW'(s4_r2) <= CMPW'(cfg.max_range_sq));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v <= accept_filter;
      end
      if (s2_en) begin
        s2_v <= s1_v && mask_q && !front_drop;
      end
      if (s3_en) begin
        s3_v <= s2_v;
      end
      if (s4_en) begin
        s4_v <= s3_v && slab_ok;
      end
      if (out_en) begin
        out_v <= s4_v && range_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_x <= in_x;
      s1_y <= in_y;
      s1_z <= in_z;
    end
    if (s2_en) begin
      s2_x  <= s1_x;
      s2_y  <= s1_y;
      s2_px <= s1_x * cfg.normal_x;
      s2_pz <= s1_z * cfg.normal_z;
      s2_xx <= sq_x;
      s2_yy <= sq_y;
      s2_zz <= sq_z;
    end
    if (s3_en) begin
      s3_x    <= s2_x;
      s3_y    <= s2_y;
      s3_slab <= SLW'(s2_px) + SLW'(s2_pz);
      s3_r2a  <= SQW'(s2_xx) + SQW'(s2_yy);
      s3_zz   <= s2_zz;
    end
    if (s4_en) begin
      s4_x  <= s3_x;
      s4_y  <= s3_y;
      s4_r2 <= s3_r2a + SQW'(s3_zz);
    end
    if (out_en) begin
      out_x <= s4_x;
      out_y <= s4_y;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = OUT_W'({out_y, out_x});

  a_ring_in_range: assert property (@(posedge clk) disable iff (rst)
    accept_filter |=> ((ring_pos == '0) || (LW'(ring_pos) < $past(len_eff))))
    else $error("ring position beyond the ring length");

  a_write_resets_ring: assert property (@(posedge clk) disable iff (rst)
    accept_write |=> (ring_pos == '0))
    else $error("mask write did not reset the ring position");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (out_v && !m_tready && s4_v && s3_v && s2_v && s1_v))
    else $error("input stalled while the pipeline had room");

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    (out_v && !$past(out_v)) |-> $past(s4_v))
    else $error("result appeared without a point in the last stage");

endmodule

// File: rtl/core/psf_ram.sv
module psf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
